[rtl/b64c_pkg.sv]
// Shared types, constants and character mapping functions for the base64 codec.
package b64c_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	localparam logic [5:0] IDX_LOWER_BASE = 6'd26;
	localparam logic [5:0] IDX_DIGIT_BASE = 6'd52;
	localparam logic [5:0] IDX_PLUS       = 6'd62;
	localparam logic [5:0] IDX_SLASH      = 6'd63;

	// One accepted item worth of results: cnt_m1 + 1 characters or bytes.
	typedef struct packed {
		logic [1:0]      cnt_m1;
		logic [3:0][7:0] chr;
		logic            present;
		logic            last;
		logic            lerr;
	} job_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < IDX_LOWER_BASE) begin
			r = CH_UPPER_A + {2'b00, v};
		end else if (v < IDX_DIGIT_BASE) begin
			r = CH_LOWER_A + {2'b00, v - IDX_LOWER_BASE};
		end else if (v == IDX_PLUS) begin
			r = CH_PLUS;
		end else if (v == IDX_SLASH) begin
			r = CH_SLASH;
		end else begin
			r = CH_DIGIT_0 + {2'b00, v - IDX_DIGIT_BASE};
		end
		return r;
	endfunction

	// Characters outside the alphabet, '=' included, map to index 0.
	function automatic logic [5:0] char_index(input logic [7:0] c);
		logic [7:0] d;
		logic [5:0] r;
		r = 6'd0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d = c - CH_UPPER_A;
			r = d[5:0];
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			d = c - CH_LOWER_A;
			r = d[5:0] + IDX_LOWER_BASE;
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			d = c - CH_DIGIT_0;
			r = d[5:0] + IDX_DIGIT_BASE;
		end else if (c == CH_PLUS) begin
			r = IDX_PLUS;
		end else if (c == CH_SLASH) begin
			r = IDX_SLASH;
		end
		return r;
	endfunction

endpackage

[rtl/b64c_front.sv]
// Front end: holds mode and group state, turns each accepted item into a job.
module b64c_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_data,
	input  logic          item_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output b64c_pkg::job_t job
);
	import b64c_pkg::*;

	logic       mode_q;
	logic [1:0] phase_q, phase_d;
	logic [5:0] carry_q, carry_d;
	logic       pad_q, pad_d;
	logic [5:0] idx;

	always_comb begin
		idx     = char_index(in_byte);
		job     = '0;
		phase_d = phase_q;
		carry_d = carry_q;
		pad_d   = pad_q;
		if (!mode_q) begin
			job.present = 1'b1;
			unique case (phase_q)
				2'd1: begin
					job.chr[0] = enc_char({carry_q[1:0], in_byte[7:4]});
					carry_d    = {2'b00, in_byte[3:0]};
					phase_d    = 2'd2;
					if (in_last) begin
						job.chr[1] = enc_char({in_byte[3:0], 2'b00});
						job.chr[2] = PAD_CHAR;
						job.cnt_m1 = 2'd2;
					end
				end
				2'd2: begin
					job.chr[0] = enc_char({carry_q[3:0], in_byte[7:6]});
					job.chr[1] = enc_char(in_byte[5:0]);
					job.cnt_m1 = 2'd1;
					carry_d    = 6'd0;
					phase_d    = 2'd0;
				end
				2'd0, 2'd3: begin
					job.chr[0] = enc_char(in_byte[7:2]);
					carry_d    = {4'b0000, in_byte[1:0]};
					phase_d    = 2'd1;
					if (in_last) begin
						job.chr[1] = enc_char({in_byte[1:0], 4'b0000});
						job.chr[2] = PAD_CHAR;
						job.chr[3] = PAD_CHAR;
						job.cnt_m1 = 2'd3;
					end
				end
			endcase
		end else begin
			unique case (phase_q)
				2'd0: begin
					carry_d = idx;
					pad_d   = 1'b0;
				end
				2'd1: begin
					job.chr[0]  = {carry_q, idx[5:4]};
					job.present = 1'b1;
					carry_d     = {2'b00, idx[3:0]};
				end
				2'd2: begin
					if (in_byte == PAD_CHAR) begin
						pad_d = 1'b1;
					end else begin
						job.chr[0]  = {carry_q[3:0], idx[5:2]};
						job.present = 1'b1;
						carry_d     = {4'b0000, idx[1:0]};
					end
				end
				2'd3: begin
					if (!pad_q && in_byte != PAD_CHAR) begin
						job.chr[0]  = {carry_q[1:0], idx};
						job.present = 1'b1;
					end
					carry_d = 6'd0;
					pad_d   = 1'b0;
				end
			endcase
			phase_d  = phase_q + 2'd1;
			job.lerr = in_last && (phase_q != 2'd3);
		end
		job.last = in_last;
		if (in_last) begin
			phase_d = 2'd0;
			carry_d = 6'd0;
			pad_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			phase_q <= 2'd0;
			carry_q <= 6'd0;
			pad_q   <= 1'b0;
		end else if (cfg_we) begin
			mode_q  <= cfg_data;
			phase_q <= 2'd0;
			carry_q <= 6'd0;
			pad_q   <= 1'b0;
		end else if (item_valid) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
			pad_q   <= pad_d;
		end
	end

endmodule

[rtl/b64c_jobq.sv]
// Two-entry job queue between the front end and the back end.
module b64c_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  b64c_pkg::job_t wr_job,
	output logic           full,
	output logic           rd_valid,
	output b64c_pkg::job_t rd_job,
	input  logic           rd_en
);
	import b64c_pkg::*;

	job_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/b64c_back.sv]
// Back end: walks the slots of the head job into the result register.
module b64c_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  b64c_pkg::job_t job,
	output logic           job_done,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           out_present,
	output logic           out_last,
	output logic           length_error
);
	import b64c_pkg::*;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       present_q, last_q, lerr_q;
	logic [1:0] slot_q;
	logic       load, final_slot;

	assign load       = job_valid && (!out_valid_q || pop);
	assign final_slot = (slot_q == job.cnt_m1);
	assign job_done   = load && final_slot;

	assign empty        = !out_valid_q;
	assign out_byte     = byte_q;
	assign out_present  = present_q;
	assign out_last     = last_q;
	assign length_error = lerr_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= job.chr[slot_q];
			present_q <= job.present;
			last_q    <= job.last && final_slot;
			lerr_q    <= job.lerr && final_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			slot_q      <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				slot_q      <= final_slot ? 2'd0 : slot_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/base64_stream_codec_top.sv]
// Top level of the streaming base64 encoder and decoder.
//
//  channel   direction  handshake          payload
//  ------------------------------------------------------------------------
//  config    in         cfg_valid/ready    cfg_decode_mode
//  input     in         push / full        in_byte, in_last
//  result    out        empty / pop        out_byte, out_present, out_last,
//                                          length_error
//
// One input byte is taken every cycle while the job queue has room; one
// result leaves per cycle through the output register while pop is held,
// so the result port sets the pace, and a flushing last byte yields up to
// four results. Reset clears mode (encode), group state, queue and result
// valid; there is no clearing pass. A stalled result side fills the
// two-entry queue, then raises full; queued results hold.
module base64_stream_codec_top (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_decode_mode,
	// input queue side
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	// result queue side
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_present,
	output logic       out_last,
	output logic       length_error
);
	import b64c_pkg::*;

	job_t front_job, head_job;
	logic item_acc, head_valid, head_done;

	// Config must only land while idle, which the block does not enforce; it always takes the transfer.
	assign cfg_ready = 1'b1;
	assign item_acc  = push && !full;

	// Classify the byte combinationally and advance group state on the accepted transfer.
	b64c_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_decode_mode),
		.item_valid (item_acc),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.job        (front_job)
	);

	// Decouple front and back so each can stall on its own.
	b64c_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (item_acc),
		.wr_job   (front_job),
		.full     (full),
		.rd_valid (head_valid),
		.rd_job   (head_job),
		.rd_en    (head_done)
	);

	// Drain each job one result per transfer.
	b64c_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (head_valid),
		.job          (head_job),
		.job_done     (head_done),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.out_present  (out_present),
		.out_last     (out_last),
		.length_error (length_error)
	);

endmodule

[rtl/b64c_checker.sv]
// Port-level checks for the base64 codec, bound to the top level.
module b64c_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       out_present,
	input logic       out_last,
	input logic       length_error
);

	// A waiting result holds until its transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last))
		else $error("result changed while stalled");

	// The queue only fills on an input transfer.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without push");

	// An empty decode result carries a zero byte.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_present |-> out_byte == 8'd0)
		else $error("absent result with nonzero byte");

	// Length error appears only on the final result of a message.
	a_lerr: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && length_error |-> out_last)
		else $error("length_error on non-final result");

endmodule

bind base64_stream_codec_top b64c_checker u_b64c_checker (.*);

[test/b64c_result_check.sv]
// Result checker for the base64 codec: tracks the codec state, predicts and compares results.
`timescale 1ns / 100ps

module b64c_result_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_decode_mode,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       out_present,
	input  logic       out_last,
	input  logic       length_error,
	output int         pending,
	output int         fail_count,
	output int         checked_count,
	output int         blank_count,
	output int         lerr_count
);
	import b64c_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
		logic       lerr;
	} codec_out_t;

	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	codec_out_t out_due_q[$];

	// codec state as seen from outside
	logic       dec_mode;
	logic [1:0] grp_pos;
	logic [5:0] carry;
	logic       pad_hit;

	int n_fail;
	int n_checked;
	int n_blank;
	int n_lerr;

	function automatic logic [7:0] alpha_char(input logic [5:0] v);
		return B64_ALPHABET[(63 - v) * 8 +: 8];
	endfunction

	// anything outside the alphabet, pad included, reads as zero
	function automatic logic [5:0] sextet(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= "A" && c <= "Z") begin
			d = c - "A";
		end else if (c >= "a" && c <= "z") begin
			d = c - "a" + 8'd26;
		end else if (c >= "0" && c <= "9") begin
			d = c - "0" + 8'd52;
		end else if (c == "+") begin
			d = 8'd62;
		end else if (c == "/") begin
			d = 8'd63;
		end
		return d[5:0];
	endfunction

	task automatic clear_group();
		grp_pos = 2'd0;
		carry   = 6'd0;
		pad_hit = 1'b0;
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic lst);
		logic [7:0] ch [4];
		logic [1:0] ph;
		codec_out_t r;
		int         n;
		int         k;
		ph = (grp_pos == 2'd3) ? 2'd0 : grp_pos;
		case (ph)
			2'd0: begin
				ch[0]   = alpha_char(b[7:2]);
				n       = 1;
				carry   = {4'd0, b[1:0]};
				grp_pos = 2'd1;
			end
			2'd1: begin
				ch[0]   = alpha_char({carry[1:0], b[7:4]});
				n       = 1;
				carry   = {2'd0, b[3:0]};
				grp_pos = 2'd2;
			end
			default: begin
				ch[0]   = alpha_char({carry[3:0], b[7:6]});
				ch[1]   = alpha_char(b[5:0]);
				n       = 2;
				carry   = 6'd0;
				grp_pos = 2'd0;
			end
		endcase
		// flush leftover bits and pad out the group
		if (lst) begin
			if (grp_pos == 2'd1) begin
				ch[n]     = alpha_char({carry[1:0], 4'd0});
				ch[n + 1] = PAD_CHAR;
				ch[n + 2] = PAD_CHAR;
				n         = n + 3;
			end else if (grp_pos == 2'd2) begin
				ch[n]     = alpha_char({carry[3:0], 2'd0});
				ch[n + 1] = PAD_CHAR;
				n         = n + 2;
			end
			clear_group();
		end
		for (k = 0; k < n; k++) begin
			r.data    = ch[k];
			r.present = 1'b1;
			r.last    = lst && (k == n - 1);
			r.lerr    = 1'b0;
			out_due_q.push_back(r);
		end
	endtask

	task automatic decode_char(input logic [7:0] c, input logic lst);
		logic [5:0] idx;
		codec_out_t r;
		idx = sextet(c);
		r   = '0;
		case (grp_pos)
			2'd0: begin
				carry   = idx;
				pad_hit = 1'b0;
			end
			2'd1: begin
				r.data    = {carry, idx[5:4]};
				r.present = 1'b1;
				carry     = {2'd0, idx[3:0]};
			end
			2'd2: begin
				if (c == PAD_CHAR) begin
					pad_hit = 1'b1;
				end else begin
					r.data    = {carry[3:0], idx[5:2]};
					r.present = 1'b1;
					carry     = {4'd0, idx[1:0]};
				end
			end
			default: begin
				if (!pad_hit && c != PAD_CHAR) begin
					r.data    = {carry[1:0], idx};
					r.present = 1'b1;
				end
				carry   = 6'd0;
				pad_hit = 1'b0;
			end
		endcase
		grp_pos = grp_pos + 2'd1;
		if (lst) begin
			r.last = 1'b1;
			r.lerr = (grp_pos != 2'd0);
			clear_group();
		end
		out_due_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		codec_out_t want;
		if (!arst_n) begin
			out_due_q.delete();
			dec_mode = 1'b0;
			clear_group();
			n_fail    = 0;
			n_checked = 0;
			n_blank   = 0;
			n_lerr    = 0;
		end else begin
			// compare first: a result never stems from an input at the same edge
			if (pop && !empty) begin
				if (out_due_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("%0t: unexpected result byte=%02h present=%0b last=%0b lerr=%0b",
							$time, out_byte, out_present, out_last, length_error);
				end else begin
					want = out_due_q.pop_front();
					n_checked++;
					if (!want.present)
						n_blank++;
					if (want.lerr)
						n_lerr++;
					if (out_byte !== want.data || out_present !== want.present ||
						out_last !== want.last || length_error !== want.lerr) begin
						n_fail++;
						if (n_fail <= 10)
							$display("%0t: mismatch want %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b %s",
								$time, want.data, want.present, want.last, want.lerr,
								out_byte, out_present, out_last, length_error,
								"(byte/present/last/lerr)");
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				dec_mode = cfg_decode_mode;
				clear_group();
			end
			if (push && !full) begin
				if (dec_mode)
					decode_char(in_byte, in_last);
				else
					encode_byte(in_byte, in_last);
			end
		end
		pending       <= out_due_q.size();
		fail_count    <= n_fail;
		checked_count <= n_checked;
		blank_count   <= n_blank;
		lerr_count    <= n_lerr;
	end

endmodule

[test/tb_top.sv]
// Testbench top for the base64 codec: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
	import b64c_pkg::*;

	// Generous cap: ~410 items, up to four results each, every result behind a
	// choked-receiver stall, plus sender gaps and the drains between phases.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 64;
	localparam int PHASE_COUNT  = 6;
	localparam int SETTLE_WAIT  = 6;

	typedef enum logic [1:0] {
		RX_STREAM,  // pop every cycle
		RX_COIN,    // pop on a coin toss
		RX_CHOKE    // long stalls, rare pops
	} rx_style_t;

	logic       clk             = 1'b0;
	logic       arst_n          = 1'b0;
	logic       cfg_valid       = 1'b0;
	logic       cfg_ready;
	logic       cfg_decode_mode = 1'b0;
	logic       push            = 1'b0;
	logic       full;
	logic [7:0] in_byte         = 8'd0;
	logic       in_last         = 1'b0;
	logic       empty;
	logic       pop             = 1'b0;
	logic [7:0] out_byte;
	logic       out_present;
	logic       out_last;
	logic       length_error;

	int chk_pending;
	int chk_fails;
	int chk_checked;
	int chk_blank;
	int chk_lerr;

	int cycle_cnt    = 0;
	int items_sent   = 0;
	int cfg_writes   = 0;
	int burst_left   = 0;
	int phase_budget = 0;

	logic [7:0] msg_q[$];

	rx_style_t rx_style = RX_STREAM;
	int        rx_left  = 0;

	always #10 clk = ~clk;

	base64_stream_codec_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_decode_mode (cfg_decode_mode),
		.push            (push),
		.full            (full),
		.in_byte         (in_byte),
		.in_last         (in_last),
		.empty           (empty),
		.pop             (pop),
		.out_byte        (out_byte),
		.out_present     (out_present),
		.out_last        (out_last),
		.length_error    (length_error)
	);

	b64c_result_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_decode_mode (cfg_decode_mode),
		.push            (push),
		.full            (full),
		.in_byte         (in_byte),
		.in_last         (in_last),
		.empty           (empty),
		.pop             (pop),
		.out_byte        (out_byte),
		.out_present     (out_present),
		.out_last        (out_last),
		.length_error    (length_error),
		.pending         (chk_pending),
		.fail_count      (chk_fails),
		.checked_count   (chk_checked),
		.blank_count     (chk_blank),
		.lerr_count      (chk_lerr)
	);

	// Watchdog: end the run if the codec or a handshake hangs.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_cnt, chk_pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: switch between free-running, coin-toss and choked popping so
	// stalls land on every phase of a flush, with clean stretches in between.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 2));
			rx_left  <= $urandom_range(10, 60);
			pop      <= 1'b1;
		end else begin
			rx_left <= rx_left - 1;
			case (rx_style)
				RX_STREAM: pop <= 1'b1;
				RX_COIN:   pop <= $urandom_range(0, 1);
				default:   pop <= (rx_left % 12 == 0);
			endcase
		end
	end

	// Send msg_q as one message, last on its final byte. Stop early once the
	// phase budget runs out, leaving the message open for the next mode write
	// to drop. Each transfer burns one unit of the sender's burst; an empty
	// burst drops push for a random gap.
	task automatic send_msg();
		int k;
		int gap;
		for (k = 0; k < msg_q.size() && phase_budget > 0; k++) begin
			push    <= 1'b1;
			in_byte <= msg_q[k];
			in_last <= (k == msg_q.size() - 1);
			do @(posedge clk); while (full);
			items_sent++;
			phase_budget--;
			burst_left--;
			if (burst_left <= 0) begin
				push <= 1'b0;
				gap = $urandom_range(1, 8);
				repeat (gap) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 12);
			end
		end
	endtask

	// Hold the sender until every predicted result has been popped, then let
	// the codec's pipeline settle.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (chk_pending != 0);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid       <= 1'b1;
		cfg_decode_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	// Load a short directed message, right-aligned in txt, first byte leftmost.
	task automatic load_text(input logic [63:0] txt, input int len);
		int k;
		msg_q.delete();
		for (k = 0; k < len; k++)
			msg_q.push_back(txt[(len - 1 - k) * 8 +: 8]);
	endtask

	initial begin : stimulus
		logic m;
		logic paused;
		int   ph;
		int   pause_at;
		int   len;
		int   groups;
		int   g;
		int   k;
		int   sel;
		logic [PHASE_COUNT-1:0] phase_modes;

		phase_modes = 6'b101100; // read from bit 0: encode, encode, decode, decode, ...
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left   = $urandom_range(1, 12);
		phase_budget = 1000;

		// Encode out of reset: one, two and three byte messages, so the flush
		// pads with two, one and no '=' characters; extreme byte values.
		load_text(64'hFF, 1);
		send_msg();
		load_text(64'h00FF, 2);
		send_msg();
		load_text(64'hFF00FF, 3);
		send_msg();

		drain();
		write_mode(1'b1);
		// Decode: pad at position three, then in the same message a group with pad
		// at position four, the alphabet edges, invalid codes and '=' early in a
		// group, and two messages of the wrong length.
		load_text("QQ==/+9=", 8);
		send_msg();
		load_text({"=", 8'hFF, "*z"}, 4);
		send_msg();
		load_text("a0Z", 3);
		send_msg();
		load_text("9", 1);
		send_msg();

		// Random phases, each behind a mode write on an idle codec.
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			drain();
			m = phase_modes[ph];
			write_mode(m);
			phase_budget = PHASE_ITEMS;
			pause_at     = $urandom_range(8, PHASE_ITEMS - 8);
			paused       = 1'b0;
			while (phase_budget > 0) begin
				msg_q.delete();
				if (!m) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
						: $urandom_range(1, 7);
					for (k = 0; k < len; k++) begin
						sel = $urandom_range(0, 9);
						msg_q.push_back((sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF
							: 8'($urandom_range(0, 255)));
					end
				end else if ($urandom_range(0, 4) == 0) begin
					// noise: any code, pads anywhere, any length
					len = $urandom_range(1, 9);
					for (k = 0; k < len; k++) begin
						sel = $urandom_range(0, 3);
						msg_q.push_back((sel == 0) ? 8'($urandom_range(0, 255))
							: (sel == 1) ? PAD_CHAR : enc_char(6'($urandom_range(0, 63))));
					end
				end else begin
					// well-formed text, often padded at the end and now and then mid-message
					groups = $urandom_range(1, 3);
					for (g = 0; g < groups; g++) begin
						for (k = 0; k < 4; k++)
							msg_q.push_back(enc_char(6'($urandom_range(0, 63))));
						if (g == groups - 1 || $urandom_range(0, 7) == 0) begin
							sel = $urandom_range(0, 2);
							if (sel != 0)
								msg_q[msg_q.size() - 1] = PAD_CHAR;
							if (sel == 2)
								msg_q[msg_q.size() - 2] = PAD_CHAR;
						end
					end
					// truncate now and then for a length error
					if ($urandom_range(0, 9) == 0)
						void'(msg_q.pop_back());
				end
				send_msg();
				if (!paused && phase_budget < pause_at) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		$display("Covered %0d input transfers across %0d mode writes; %0d results compared.",
			items_sent, cfg_writes, chk_checked);
		$display("Seen: %0d suppressed decode results, %0d length errors, %0d failures.",
			chk_blank, chk_lerr, chk_fails);
		if (chk_fails == 0 && chk_pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/b64c_pkg.sv
rtl/b64c_front.sv
rtl/b64c_jobq.sv
rtl/b64c_back.sv
rtl/base64_stream_codec_top.sv
rtl/b64c_checker.sv
test/b64c_result_check.sv
test/tb_top.sv
